// File: rtl/serial_time_sync_clock_assert.svh
// ----------------------------------------------------------------------------
// serial_time_sync_clock assertion macros
// Clocked assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef SERIAL_TIME_SYNC_CLOCK_ASSERT_SVH
`define SERIAL_TIME_SYNC_CLOCK_ASSERT_SVH

`ifndef SYNTHESIS
// Check prop on every rising clk edge, disabled while rst_n is low
`define STS_ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check prop on the block clock and reset
`define STS_ASSERT(label, prop, msg) \
    `STS_ASSERT_AT(label, aclk, aresetn, prop, msg)
`else
`define STS_ASSERT_AT(label, clk, rst_n, prop, msg)
`define STS_ASSERT(label, prop, msg)
`endif

`endif

// File: rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types and constants shared by the serial time sync clock modules.
// ----------------------------------------------------------------------------
package sts_pkg;

    // Beat kinds carried on s_tuser
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Frame header bytes
    localparam logic [7:0] HDR_EPOCH = 8'hA1;
    localparam logic [7:0] HDR_LOCAL = 8'hA2;

    // Only the header and the twelve payload bytes that follow are ever read
    localparam int HOLD_BYTES = 13;
    localparam int HOLD_IDX_W = $clog2(HOLD_BYTES);

    // Clock field limits
    localparam logic [7:0] LIM_HUNDREDTHS = 8'd99;
    localparam logic [7:0] LIM_SECONDS    = 8'd59;
    localparam logic [7:0] LIM_MINUTES    = 8'd59;
    localparam logic [7:0] LIM_HOURS      = 8'd23;
    localparam logic [6:0] TICKS_PER_SEC  = 7'd100;

    localparam logic [7:0] TIMEOUT_RESET  = 8'd5;
    localparam logic [7:0] COUNT_MAX      = 8'd255;

    typedef enum logic [1:0] {
        STAT_NONE    = 2'd0,
        STAT_LOCAL   = 2'd1,
        STAT_EPOCH   = 2'd2,
        STAT_INVALID = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [7:0] hundredths;
    } tod_t;

    typedef struct packed {
        logic [15:0] year;
        logic [15:0] month;
        logic [15:0] day;
        logic [15:0] weekday;
    } date_t;

    // Frame close event from the receiver to the timekeeper
    typedef struct packed {
        logic          done;
        frame_status_t status;
        logic [7:0]    length;
        date_t         cal;
        tod_t          tod;
        logic [31:0]   epoch;
    } frame_close_t;

    // Timekeeping state after the current beat
    typedef struct packed {
        tod_t        tod;
        date_t       cal;
        logic [31:0] epoch;
    } time_view_t;

    typedef struct packed {
        logic       carry;
        logic [7:0] val;
    } bump_t;

    localparam int OUT_DATA_W = 136;

endpackage

// File: rtl/sts_frame.sv
// ----------------------------------------------------------------------------
// sts_frame
// Serial frame receiver: stores bytes, counts idle ticks and decodes the
// header when a frame closes on idle timeout.
// ----------------------------------------------------------------------------
module sts_frame (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    input  logic                  item_en,
    input  logic                  item_mode,
    input  logic [7:0]            item_byte,
    output sts_pkg::frame_close_t close
);

    logic [7:0] timeout_reg;
    logic [7:0] byte_count_reg;
    logic       receiving_reg;
    logic [7:0] idle_count_reg;
    logic [7:0] store_reg [sts_pkg::HOLD_BYTES];
    logic [7:0] rd_byte   [sts_pkg::HOLD_BYTES];
    logic       byte_en;
    logic       tick_en;

    assign byte_en = item_en && (item_mode == sts_pkg::MODE_BYTE);
    assign tick_en = item_en && (item_mode == sts_pkg::MODE_TICK);

    // Store entries past the fill count read as zero, so no clear is needed
    always_comb begin
        for (int i = 0; i < sts_pkg::HOLD_BYTES; i++) begin
            rd_byte[i] = (8'(i) < byte_count_reg) ? store_reg[i] : 8'd0;
        end
    end

    // Write the byte at the fill position; drop bytes past the held range
    always_ff @(posedge aclk) begin
        if (byte_en && (byte_count_reg < 8'(sts_pkg::HOLD_BYTES))) begin
            store_reg[byte_count_reg[sts_pkg::HOLD_IDX_W-1:0]] <= item_byte;
        end
    end

    // Decode the header on idle timeout
    always_comb begin
        close        = '0;
        close.done   = tick_en && receiving_reg && (idle_count_reg >= timeout_reg);
        close.length = close.done ? byte_count_reg : 8'd0;
        close.cal    = {rd_byte[1], rd_byte[2], rd_byte[3], rd_byte[4],
                        rd_byte[5], rd_byte[6], rd_byte[7], rd_byte[8]};
        close.tod    = {rd_byte[9], rd_byte[10], rd_byte[11], rd_byte[12]};
        close.epoch  = {rd_byte[1], rd_byte[2], rd_byte[3], rd_byte[4]};
        if (close.done) begin
            if (rd_byte[0] == sts_pkg::HDR_LOCAL) begin
                close.status = sts_pkg::STAT_LOCAL;
            end else if (rd_byte[0] == sts_pkg::HDR_EPOCH) begin
                close.status = sts_pkg::STAT_EPOCH;
            end else begin
                close.status = sts_pkg::STAT_INVALID;
            end
        end
    end

    // Track byte count, idle ticks and the receive flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= sts_pkg::TIMEOUT_RESET;
            byte_count_reg <= '0;
            receiving_reg  <= 1'b0;
            idle_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (byte_en) begin
                receiving_reg  <= 1'b1;
                idle_count_reg <= '0;
                if (byte_count_reg != sts_pkg::COUNT_MAX) begin
                    byte_count_reg <= byte_count_reg + 8'd1;
                end
            end else if (tick_en && receiving_reg) begin
                if (idle_count_reg != sts_pkg::COUNT_MAX) begin
                    idle_count_reg <= idle_count_reg + 8'd1;
                end
                if (close.done) begin
                    receiving_reg  <= 1'b0;
                    byte_count_reg <= '0;
                end
            end
        end
    end

`include "serial_time_sync_clock_assert.svh"

    `STS_ASSERT(a_close_needs_frame, close.done |-> receiving_reg, "frame closed while not receiving")
    `STS_ASSERT(a_recv_ends_on_close, $fell(receiving_reg) |-> $past(close.done), "receive dropped without close")
    `STS_ASSERT(a_count_idle_zero, !receiving_reg |-> (byte_count_reg == 8'd0), "bytes held outside a frame")

endmodule

// File: rtl/sts_timekeeper.sv
// ----------------------------------------------------------------------------
// sts_timekeeper
// Time-of-day clock, seconds counter and calendar, advanced by ticks and
// loaded by closed frames.
// ----------------------------------------------------------------------------
module sts_timekeeper (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_en,
    input  logic                  item_mode,
    input  sts_pkg::frame_close_t close,
    output sts_pkg::time_view_t   view
);

    sts_pkg::tod_t  tod_reg;
    sts_pkg::tod_t  tod_next;
    sts_pkg::date_t cal_reg;
    sts_pkg::date_t cal_next;
    logic [31:0]    epoch_reg;
    logic [31:0]    epoch_next;
    logic [6:0]     tick_reg;
    logic [6:0]     tick_next;
    sts_pkg::bump_t b_hu;
    sts_pkg::bump_t b_se;
    sts_pkg::bump_t b_mi;
    sts_pkg::bump_t b_hr;
    logic           tick_en;

    // Count a field up; wrap to zero with carry once it passes its limit
    function automatic sts_pkg::bump_t bump(input logic [7:0] v, input logic [7:0] limit);
        sts_pkg::bump_t r;
        logic [7:0]     n;
        n = v + 8'd1;
        if (n > limit) begin
            r.carry = 1'b1;
            r.val   = 8'd0;
        end else begin
            r.carry = 1'b0;
            r.val   = n;
        end
        return r;
    endfunction

    assign tick_en = item_en && (item_mode == sts_pkg::MODE_TICK);

    // Advance on tick, then let a closing frame overwrite
    always_comb begin
        tod_next   = tod_reg;
        cal_next   = cal_reg;
        epoch_next = epoch_reg;
        tick_next  = tick_reg;
        b_hu = bump(tod_reg.hundredths, sts_pkg::LIM_HUNDREDTHS);
        b_se = bump(tod_reg.seconds, sts_pkg::LIM_SECONDS);
        b_mi = bump(tod_reg.minutes, sts_pkg::LIM_MINUTES);
        b_hr = bump(tod_reg.hours, sts_pkg::LIM_HOURS);
        if (tick_en) begin
            tod_next.hundredths = b_hu.val;
            if (b_hu.carry) begin
                tod_next.seconds = b_se.val;
                if (b_se.carry) begin
                    tod_next.minutes = b_mi.val;
                    if (b_mi.carry) begin
                        tod_next.hours = b_hr.val;
                    end
                end
            end
            if (tick_reg == sts_pkg::TICKS_PER_SEC - 7'd1) begin
                tick_next  = '0;
                epoch_next = epoch_reg + 32'd1;
            end else begin
                tick_next = tick_reg + 7'd1;
            end
        end
        if (close.done) begin
            case (close.status)
                sts_pkg::STAT_LOCAL: begin
                    cal_next = close.cal;
                    tod_next = close.tod;
                end
                sts_pkg::STAT_EPOCH: begin
                    epoch_next = close.epoch;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tod_reg   <= '0;
            cal_reg   <= '0;
            epoch_reg <= '0;
            tick_reg  <= '0;
        end else begin
            tod_reg   <= tod_next;
            cal_reg   <= cal_next;
            epoch_reg <= epoch_next;
            tick_reg  <= tick_next;
        end
    end

    assign view.tod   = tod_next;
    assign view.cal   = cal_next;
    assign view.epoch = epoch_next;

endmodule

// File: rtl/serial_time_sync_clock.sv
// An accepted input beat is held in the input register, then loaded into the result register.
// Throughput: one beat per cycle while m_tready holds; the state update is combinational
// between the input register and the result register.
// Reset (aresetn low, synchronous): clock, calendar, seconds counter, frame
// state and both beat registers clear; idle timeout returns to 5 ticks.
// ----------------------------------------------------------------------------
// serial_time_sync_clock
// Serial time sync receiver with a 10 ms tick driven time-of-day clock.
// ----------------------------------------------------------------------------
module serial_time_sync_clock (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,    // idle_timeout_ticks
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,        // [7:0] rx_byte
    input  logic         s_tuser,        // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] hours, [15:8] minutes, [23:16] seconds_of_minute,
    // [31:24] hundredths, [47:32] year, [63:48] month_number,
    // [79:64] day_of_month, [95:80] weekday, [127:96] epoch_seconds,
    // [135:128] frame_length
    output logic [135:0] m_tdata,
    output logic         m_tlast,        // frame_done
    output logic [1:0]   m_tuser         // [1:0] frame_status
);

    logic                  in_valid_reg;
    logic                  in_mode_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_advance;
    logic                  out_valid_reg;
    logic [sts_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;
    logic [1:0]            out_user_reg;
    sts_pkg::frame_close_t close;
    sts_pkg::time_view_t   view;

    // Process the held beat when the result register is free or draining
    assign in_advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || in_advance;

    // Input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    sts_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_en     (in_advance),
        .item_mode   (in_mode_reg),
        .item_byte   (in_byte_reg),
        .close       (close)
    );

    sts_timekeeper u_timekeeper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_en   (in_advance),
        .item_mode (in_mode_reg),
        .close     (close),
        .view      (view)
    );

    // Result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            out_data_reg <= {close.length, view.epoch,
                             view.cal.weekday, view.cal.day,
                             view.cal.month, view.cal.year,
                             view.tod.hundredths, view.tod.seconds,
                             view.tod.minutes, view.tod.hours};
            out_last_reg <= close.done;
            out_user_reg <= close.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

`include "serial_time_sync_clock_assert.svh"

    `STS_ASSERT(a_status_only_on_close, (m_tvalid && !m_tlast) |-> (m_tuser == sts_pkg::STAT_NONE), "status without frame close")
    `STS_ASSERT(a_length_only_on_close, (m_tvalid && !m_tlast) |-> (m_tdata[135:128] == 8'd0), "length without frame close")
    `STS_ASSERT(a_result_from_beat, $rose(m_tvalid) |-> $past(in_advance), "result beat without an input beat")

endmodule
